// File: rtl/barycentric_coordinates_top_assert.svh
// Assertion macros shared by the barycentric block.
`ifndef BARYCENTRIC_COORDINATES_TOP_ASSERT_SVH
`define BARYCENTRIC_COORDINATES_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bc_pkg.sv
package bc_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 24;

    // edge and offset components
    localparam int DIFF_W = COORD_BITS + 1;
    // component products
    localparam int PROD_W = 2 * DIFF_W;
    // dot products: sum of three products
    localparam int DOT_W  = 2 * COORD_BITS + 3;
    // products of dot products and their differences
    localparam int NUM_W  = 4 * COORD_BITS + 6;
    // determinant and numerator magnitudes
    localparam int DEN_W  = NUM_W - 1;
    // scaled, rounded dividend; also the quotient width
    localparam int DVD_W  = DEN_W + FRAC_BITS + 1;
    // signed quotient and weight sum
    localparam int SQ_W   = DVD_W + 1;
    localparam int SU_W   = SQ_W + 2;

    localparam int OUT_MAX = (1 << (OUT_BITS - 1)) - 1;
    localparam int OUT_MIN = -(1 << (OUT_BITS - 1));

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_a_x;
        logic signed [COORD_BITS-1:0] vertex_a_y;
        logic signed [COORD_BITS-1:0] vertex_a_z;
        logic signed [COORD_BITS-1:0] vertex_b_x;
        logic signed [COORD_BITS-1:0] vertex_b_y;
        logic signed [COORD_BITS-1:0] vertex_b_z;
        logic signed [COORD_BITS-1:0] vertex_c_x;
        logic signed [COORD_BITS-1:0] vertex_c_y;
        logic signed [COORD_BITS-1:0] vertex_c_z;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
    } t_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] weight_u;
        logic signed [OUT_BITS-1:0] weight_v;
        logic signed [OUT_BITS-1:0] weight_w;
        logic                       degenerate;
    } t_out;

    // divider stage contents; the dividend registers fill with quotient bits
    typedef struct packed {
        logic [DEN_W-1:0] rem_v;
        logic [DEN_W-1:0] rem_w;
        logic [DVD_W-1:0] q_v;
        logic [DVD_W-1:0] q_w;
        logic [DEN_W-1:0] den;
        logic             neg_v;
        logic             neg_w;
        logic             degenerate;
    } t_div;

endpackage

// File: rtl/barycentric_coordinates_top.sv
// channel   direction  valid    ready    payload
// input     in         i_valid  o_ready  i_data (t_in)
// result    out        o_valid  i_ready  o_data (t_out)
//
// One transaction per cycle sustained while the result is not stalled; the results come
// from the one-bit-per-stage restoring divider, which follows six front stages.
// Reset (synchronous, active low) clears all stage valid bits; the pipeline is empty after it.
// A stalled result freezes the whole pipeline: o_ready drops until the result is taken.
module barycentric_coordinates_top
    import bc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

`include "barycentric_coordinates_top_assert.svh"

    localparam logic signed [SU_W-1:0] SAT_HI = SU_W'(OUT_MAX);
    localparam logic signed [SU_W-1:0] SAT_LO = SU_W'(OUT_MIN);
    localparam logic signed [SU_W-1:0] ONE    = SU_W'(1) <<< FRAC_BITS;

    function automatic logic signed [OUT_BITS-1:0] sat(logic signed [SU_W-1:0] x);
        if (x > SAT_HI) begin
            return OUT_BITS'(OUT_MAX);
        end else if (x < SAT_LO) begin
            return OUT_BITS'(OUT_MIN);
        end
        return x[OUT_BITS-1:0];
    endfunction

    logic w_en;
    logic w_fv, w_dv;
    t_div w_fd, w_dd;

    logic                     r_sv, r_ov;
    logic signed [SQ_W-1:0]   r_qv, r_qw;
    logic                     r_deg;
    t_out                     r_out;
    logic signed [SU_W-1:0]   w_u;

    assign w_en    = !r_ov || i_ready;
    assign o_ready = w_en;

    bc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (w_fv),
        .o_div   (w_fd)
    );

    bc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_div   (w_fd),
        .o_valid (w_dv),
        .o_div   (w_dd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_sv <= w_dv;
            r_ov <= r_sv;
        end
    end

    assign w_u = ONE - SU_W'(r_qv) - SU_W'(r_qw);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qv  <= w_dd.neg_v ? -SQ_W'(w_dd.q_v) : SQ_W'(w_dd.q_v);
            r_qw  <= w_dd.neg_w ? -SQ_W'(w_dd.q_w) : SQ_W'(w_dd.q_w);
            r_deg <= w_dd.degenerate;
            if (r_deg) begin
                r_out <= '{weight_u: '0, weight_v: '0, weight_w: '0, degenerate: 1'b1};
            end else begin
                r_out.weight_u   <= sat(w_u);
                r_out.weight_v   <= sat(SU_W'(r_qv));
                r_out.weight_w   <= sat(SU_W'(r_qw));
                r_out.degenerate <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    `BC_ASSERT_NOW(a_deg_zero, i_clk, i_rst_n, o_valid && o_data.degenerate,
        o_data.weight_u == '0 && o_data.weight_v == '0 && o_data.weight_w == '0,
        "degenerate result carries nonzero weights")
    `BC_ASSERT_NOW(a_stall_blocks, i_clk, i_rst_n, o_valid && !i_ready, !o_ready,
        "input accepted while the result is stalled")
    `BC_ASSERT_NEXT(a_stall_hold_pipe, i_clk, i_rst_n, o_valid && !i_ready && r_sv, r_sv,
        "stage valid lost during a stall")
    `BC_ASSERT_NOW(a_sum_one, i_clk, i_rst_n,
        o_valid && !o_data.degenerate
        && o_data.weight_u != OUT_BITS'(OUT_MAX) && o_data.weight_u != OUT_BITS'(OUT_MIN)
        && o_data.weight_v != OUT_BITS'(OUT_MAX) && o_data.weight_v != OUT_BITS'(OUT_MIN)
        && o_data.weight_w != OUT_BITS'(OUT_MAX) && o_data.weight_w != OUT_BITS'(OUT_MIN),
        OUT_BITS'(o_data.weight_u + o_data.weight_v + o_data.weight_w)
        == OUT_BITS'(ONE),
        "unsaturated weights do not sum to one")

endmodule

// File: rtl/bc_front.sv
module bc_front
    import bc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_valid,
    output t_div o_div
);

    logic signed [COORD_BITS-1:0] w_a[3], w_b[3], w_c[3], w_p[3];

    assign w_a[0] = i_data.vertex_a_x;
    assign w_a[1] = i_data.vertex_a_y;
    assign w_a[2] = i_data.vertex_a_z;
    assign w_b[0] = i_data.vertex_b_x;
    assign w_b[1] = i_data.vertex_b_y;
    assign w_b[2] = i_data.vertex_b_z;
    assign w_c[0] = i_data.vertex_c_x;
    assign w_c[1] = i_data.vertex_c_y;
    assign w_c[2] = i_data.vertex_c_z;
    assign w_p[0] = i_data.point_x;
    assign w_p[1] = i_data.point_y;
    assign w_p[2] = i_data.point_z;

    logic [5:0] r_v;

    logic signed [DIFF_W-1:0] r_e1[3], r_e2[3], r_q[3];
    logic signed [PROD_W-1:0] r_p00[3], r_p01[3], r_p11[3], r_p20[3], r_p21[3];
    logic signed [DOT_W-1:0]  r_d00, r_d01, r_d11, r_d20, r_d21;
    logic signed [NUM_W-1:0]  r_t0011, r_t0101, r_t1120, r_t0121, r_t0021, r_t0120;
    logic signed [NUM_W-1:0]  r_den, r_nv, r_nw;
    logic signed [NUM_W-1:0]  w_av, w_aw;
    t_div                     r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= DIFF_W'(w_b[k]) - DIFF_W'(w_a[k]);
                r_e2[k] <= DIFF_W'(w_c[k]) - DIFF_W'(w_a[k]);
                r_q[k]  <= DIFF_W'(w_p[k]) - DIFF_W'(w_a[k]);
                r_p00[k] <= PROD_W'(r_e1[k]) * PROD_W'(r_e1[k]);
                r_p01[k] <= PROD_W'(r_e1[k]) * PROD_W'(r_e2[k]);
                r_p11[k] <= PROD_W'(r_e2[k]) * PROD_W'(r_e2[k]);
                r_p20[k] <= PROD_W'(r_q[k]) * PROD_W'(r_e1[k]);
                r_p21[k] <= PROD_W'(r_q[k]) * PROD_W'(r_e2[k]);
            end
            r_d00 <= DOT_W'(r_p00[0]) + DOT_W'(r_p00[1]) + DOT_W'(r_p00[2]);
            r_d01 <= DOT_W'(r_p01[0]) + DOT_W'(r_p01[1]) + DOT_W'(r_p01[2]);
            r_d11 <= DOT_W'(r_p11[0]) + DOT_W'(r_p11[1]) + DOT_W'(r_p11[2]);
            r_d20 <= DOT_W'(r_p20[0]) + DOT_W'(r_p20[1]) + DOT_W'(r_p20[2]);
            r_d21 <= DOT_W'(r_p21[0]) + DOT_W'(r_p21[1]) + DOT_W'(r_p21[2]);
            r_t0011 <= NUM_W'(r_d00) * NUM_W'(r_d11);
            r_t0101 <= NUM_W'(r_d01) * NUM_W'(r_d01);
            r_t1120 <= NUM_W'(r_d11) * NUM_W'(r_d20);
            r_t0121 <= NUM_W'(r_d01) * NUM_W'(r_d21);
            r_t0021 <= NUM_W'(r_d00) * NUM_W'(r_d21);
            r_t0120 <= NUM_W'(r_d01) * NUM_W'(r_d20);
            r_den <= r_t0011 - r_t0101;
            r_nv  <= r_t1120 - r_t0121;
            r_nw  <= r_t0021 - r_t0120;
            r_out.rem_v      <= '0;
            r_out.rem_w      <= '0;
            r_out.q_v        <= {w_av[DEN_W-1:0], FRAC_BITS'(0)} + DVD_W'(r_den[DEN_W-1:1]);
            r_out.q_w        <= {w_aw[DEN_W-1:0], FRAC_BITS'(0)} + DVD_W'(r_den[DEN_W-1:1]);
            r_out.den        <= r_den[DEN_W-1:0];
            r_out.neg_v      <= r_nv[NUM_W-1];
            r_out.neg_w      <= r_nw[NUM_W-1];
            r_out.degenerate <= (r_den == '0);
        end
    end

    // the Gram determinant is never negative, so only the numerators need magnitudes
    assign w_av = r_nv[NUM_W-1] ? -r_nv : r_nv;
    assign w_aw = r_nw[NUM_W-1] ? -r_nw : r_nw;

    assign o_valid = r_v[5];
    assign o_div   = r_out;

endmodule

// File: rtl/bc_div.sv
module bc_div
    import bc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_div,
    output logic o_valid,
    output t_div o_div
);

    // one restoring step for both quotients against the shared divisor
    function automatic t_div div_step(t_div a);
        t_div             r;
        logic [DEN_W:0]   tv, tw;
        logic             bv, bw;
        r  = a;
        tv = {a.rem_v, a.q_v[DVD_W-1]};
        tw = {a.rem_w, a.q_w[DVD_W-1]};
        bv = (tv >= {1'b0, a.den});
        bw = (tw >= {1'b0, a.den});
        r.rem_v = bv ? DEN_W'(tv - {1'b0, a.den}) : tv[DEN_W-1:0];
        r.rem_w = bw ? DEN_W'(tw - {1'b0, a.den}) : tw[DEN_W-1:0];
        r.q_v   = {a.q_v[DVD_W-2:0], bv};
        r.q_w   = {a.q_w[DVD_W-2:0], bw};
        return r;
    endfunction

    t_div r_st[DVD_W];
    logic r_v[DVD_W];

    for (genvar k = 0; k < DVD_W; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k - 1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= div_step((k == 0) ? i_div : r_st[(k == 0) ? 0 : k - 1]);
            end
        end
    end

    assign o_valid = r_v[DVD_W-1];
    assign o_div   = r_st[DVD_W-1];

endmodule

// File: sim/tb_top.sv
module tb_top;
    import bc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    class weight_scoreboard;
        t_out expected_q[$];
        int   errors = 0;

        static function logic signed [OUT_BITS-1:0] clamp(logic signed [127:0] a);
            if (a > OUT_MAX) return OUT_BITS'(OUT_MAX);
            if (a < OUT_MIN) return OUT_BITS'(OUT_MIN);
            return a[OUT_BITS-1:0];
        endfunction

        // round(num * 2^FRAC_BITS / den), halves away from zero
        static function logic signed [127:0] scaled_div(longint num, longint den);
            logic [127:0] n, d, q;
            bit neg;
            neg = (num < 0) != (den < 0);
            n = (num < 0) ? 128'(-num) : 128'(num);
            d = (den < 0) ? 128'(-den) : 128'(den);
            q = ((n << FRAC_BITS) + (d >> 1)) / d;
            return neg ? -$signed(q) : $signed(q);
        endfunction

        function void note_input(t_in d);
            longint e1[3], e2[3], q[3], a[3];
            longint d00, d01, d11, d20, d21, den, nv, nw;
            logic signed [127:0] v, w, u;
            t_out r;
            a = '{longint'(d.vertex_a_x), longint'(d.vertex_a_y), longint'(d.vertex_a_z)};
            e1 = '{longint'(d.vertex_b_x) - a[0], longint'(d.vertex_b_y) - a[1],
                   longint'(d.vertex_b_z) - a[2]};
            e2 = '{longint'(d.vertex_c_x) - a[0], longint'(d.vertex_c_y) - a[1],
                   longint'(d.vertex_c_z) - a[2]};
            q  = '{longint'(d.point_x) - a[0], longint'(d.point_y) - a[1],
                   longint'(d.point_z) - a[2]};
            d00 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
            d01 = e1[0]*e2[0] + e1[1]*e2[1] + e1[2]*e2[2];
            d11 = e2[0]*e2[0] + e2[1]*e2[1] + e2[2]*e2[2];
            d20 = q[0]*e1[0] + q[1]*e1[1] + q[2]*e1[2];
            d21 = q[0]*e2[0] + q[1]*e2[1] + q[2]*e2[2];
            den = d00*d11 - d01*d01;
            r = '0;
            if (den == 0) begin
                r.degenerate = 1'b1;
            end else begin
                nv = d11*d20 - d01*d21;
                nw = d00*d21 - d01*d20;
                v = scaled_div(nv, den);
                w = scaled_div(nw, den);
                u = (128'sd1 <<< FRAC_BITS) - v - w;
                r.weight_u = clamp(u);
                r.weight_v = clamp(v);
                r.weight_w = clamp(w);
            end
            expected_q = {expected_q, r};
        endfunction

        function void check_result(t_out got);
            t_out e;
            if (expected_q.size() == 0) begin
                $error("result with no transaction pending: %h", got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.weight_u !== e.weight_u) begin
                $error("weight_u expected %0d actual %0d", e.weight_u, got.weight_u);
                errors++;
            end
            if (got.weight_v !== e.weight_v) begin
                $error("weight_v expected %0d actual %0d", e.weight_v, got.weight_v);
                errors++;
            end
            if (got.weight_w !== e.weight_w) begin
                $error("weight_w expected %0d actual %0d", e.weight_w, got.weight_w);
                errors++;
            end
            if (got.degenerate !== e.degenerate) begin
                $error("degenerate expected %0d actual %0d", e.degenerate, got.degenerate);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_data = '0;
    logic o_ready, o_valid;
    t_out o_data;

    int idle_pct = 0;
    int stall_pct = 0;
    weight_scoreboard sb = new();

    barycentric_coordinates_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // sample mid-cycle: inputs change only at the rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
    end

    task automatic send_item(t_in d);
        while ($urandom_range(99) < idle_pct) begin
            @(posedge i_clk);
            i_valid <= 1'b0;
        end
        @(posedge i_clk);
        i_valid <= 1'b1;
        i_data  <= d;
        do @(negedge i_clk); while (!(i_valid && o_ready));
        sb.note_input(d);
    endtask

    function automatic logic signed [COORD_BITS-1:0] rnd_coord(int span);
        if (span == 0) return COORD_BITS'($urandom());
        return COORD_BITS'($signed($urandom_range(2*span)) - span);
    endfunction

    function automatic t_in make_item();
        t_in d;
        int k, mode, span;
        mode = $urandom_range(9);
        span = ($urandom_range(3) == 0) ? 0 : (1 << $urandom_range(10, 2));
        d = '0;
        d.vertex_a_x = rnd_coord(span); d.vertex_a_y = rnd_coord(span);
        d.vertex_a_z = rnd_coord(span);
        d.vertex_b_x = rnd_coord(span); d.vertex_b_y = rnd_coord(span);
        d.vertex_b_z = rnd_coord(span);
        d.vertex_c_x = rnd_coord(span); d.vertex_c_y = rnd_coord(span);
        d.vertex_c_z = rnd_coord(span);
        d.point_x = rnd_coord(span); d.point_y = rnd_coord(span); d.point_z = rnd_coord(span);
        case (mode)
            0: begin
                // coincident vertices
                d.vertex_c_x = d.vertex_a_x; d.vertex_c_y = d.vertex_a_y;
                d.vertex_c_z = d.vertex_a_z;
            end
            1: begin
                // collinear: c on line through a and b
                k = int'($urandom_range(2)) - 1;
                d.vertex_c_x = COORD_BITS'(d.vertex_a_x + k * (d.vertex_b_x - d.vertex_a_x));
                d.vertex_c_y = COORD_BITS'(d.vertex_a_y + k * (d.vertex_b_y - d.vertex_a_y));
                d.vertex_c_z = COORD_BITS'(d.vertex_a_z + k * (d.vertex_b_z - d.vertex_a_z));
            end
            2: begin
                d.point_x = d.vertex_b_x; d.point_y = d.vertex_b_y; d.point_z = d.vertex_b_z;
            end
            3: begin
                // nearly flat triangle drives weights to saturation
                d.vertex_c_x = COORD_BITS'(d.vertex_b_x + 1); d.vertex_c_y = d.vertex_b_y;
                d.vertex_c_z = d.vertex_b_z;
            end
            default: ;
        endcase
        return d;
    endfunction

    task automatic drain();
        while (sb.expected_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        t_in d;
        int p;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        d = '0; send_item(d);
        d = {12{12'sh7ff}}; send_item(d);
        d = {12{12'sh800}}; send_item(d);
        d = '0;
        d.vertex_b_x = 12'sh7ff; d.vertex_c_y = 12'sh7ff;
        d.point_x = 12'sh100; d.point_y = 12'sh100;
        send_item(d);
        d.point_x = 12'sh800; d.point_y = 12'sh800; d.point_z = 12'sh7ff; send_item(d);
        d.vertex_a_x = 12'sh800; d.vertex_a_y = 12'sh800; d.vertex_a_z = 12'sh800;
        d.vertex_b_x = 12'sh7ff; d.vertex_b_y = 12'sh800; d.vertex_b_z = 12'sh7ff;
        d.vertex_c_x = 12'sh800; d.vertex_c_y = 12'sh7ff; d.vertex_c_z = 12'sh7ff;
        d.point_x = 12'sh7ff; d.point_y = 12'sh7ff; d.point_z = 12'sh800;
        send_item(d);
        d.point_x = d.vertex_a_x; d.point_y = d.vertex_a_y; d.point_z = d.vertex_a_z;
        send_item(d);
        d.point_x = d.vertex_c_x; d.point_y = d.vertex_c_y; d.point_z = d.vertex_c_z;
        send_item(d);
        d = '0; d.vertex_b_x = 12'sd1; d.vertex_c_x = 12'sd2; d.point_y = 12'sd5;
        send_item(d);
        d = '0; d.vertex_b_x = 12'sd1; d.vertex_c_x = 12'sd1; d.vertex_c_y = 12'sd1;
        d.point_x = 12'sh7ff; d.point_y = 12'sh800; send_item(d);
        d = '0; d.vertex_b_x = 12'sd3; d.vertex_c_y = 12'sd3;
        d.point_x = 12'sd1; d.point_y = 12'sd1; send_item(d);
        for (p = 0; p < 14; p++) send_item(make_item());
        // drop valid once the last transaction is taken
        @(posedge i_clk);
        i_valid <= 1'b0;
        drain();

        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            repeat (220) send_item(make_item());
            // hold the sender off until the pipeline is empty
            @(posedge i_clk);
            i_valid <= 1'b0;
            drain();
        end
        stall_pct = 0;
        drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("[barycentric_coordinates_top] OK");
        end else begin
            $display("[barycentric_coordinates_top] ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("[barycentric_coordinates_top] ERROR");
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/bc_pkg.sv
rtl/bc_front.sv
rtl/bc_div.sv
rtl/barycentric_coordinates_top.sv
sim/tb_top.sv
